// ===== rtl/tgfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgfe_pkg: shared types and constants
// Request layouts, the band gain table and the register and function codes
// used by the three-band FIR equalizer.
// ----------------------------------------------------------------------------
package tgfe_pkg;

    localparam int DATA_W    = 16;
    localparam int BAND_CNT  = 3;
    localparam int SEL_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * DATA_W;

    localparam logic [SEL_W-1:0] SEL_RESET = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HIGH = 2'd2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic                     func;
        logic [1:0]               band;
        logic [7:0]               tap_index;
        logic signed [DATA_W-1:0] coefficient;
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] left_out;
        logic signed [DATA_W-1:0] right_out;
    } t_out_item;

    typedef struct packed {
        logic [SEL_W-1:0] low;
        logic [SEL_W-1:0] mid;
        logic [SEL_W-1:0] high;
    } t_gain_sel;

    // Index 0 is the low band, 2 the high band.
    typedef logic [BAND_CNT-1:0][DATA_W-1:0] t_coef_word;

    // Index 1 is left, 0 is right.
    typedef logic [1:0][DATA_W-1:0] t_hist_word;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic live;
    } t_tap_tag;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_PUSH,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    function automatic logic signed [DATA_W-1:0] gain_of(input logic [SEL_W-1:0] sel);
        logic signed [DATA_W-1:0] g;
        case (sel)
            3'd0:    g = 16'sh080A;
            3'd1:    g = 16'sh100A;
            3'd2:    g = 16'sh16A7;
            3'd3:    g = 16'sh2000;
            3'd4:    g = 16'sh2D34;
            3'd5:    g = 16'sh3FD9;
            default: g = 16'sh7F65;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tgfe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgfe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tgfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/tgfe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgfe_ctrl: request sequencer
// Accepts requests, performs coefficient read-modify-write for loads, pushes
// samples into the history ring and walks the taps of one sample.
// ----------------------------------------------------------------------------
module tgfe_ctrl
    import tgfe_pkg::*;
#(
    parameter int NUM_TAPS = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire t_in_item                    i_in_data,
    output logic                             o_in_ready,
    input  wire logic                        i_out_free,
    input  wire logic                        i_done,
    output logic                             o_load_out,
    input  wire t_coef_word                  i_coef_rdata,
    output logic [$clog2(NUM_TAPS)-1:0]      o_coef_raddr,
    output logic                             o_coef_we,
    output logic [$clog2(NUM_TAPS)-1:0]      o_coef_waddr,
    output t_coef_word                       o_coef_wdata,
    output logic [$clog2(NUM_TAPS)-1:0]      o_hist_raddr,
    output logic                             o_hist_we,
    output logic [$clog2(NUM_TAPS)-1:0]      o_hist_waddr,
    output t_hist_word                       o_hist_wdata,
    output t_tap_tag                         o_tag
);

    localparam int TAP_W  = $clog2(NUM_TAPS);
    localparam int FILL_W = $clog2(NUM_TAPS + 1);
    localparam logic [TAP_W-1:0]  K_LAST   = TAP_W'(NUM_TAPS - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(NUM_TAPS);

    t_state             r_state;
    t_state             n_state;
    t_in_item           r_req;
    logic [TAP_W-1:0]   r_head;
    logic [FILL_W-1:0]  r_fill;
    logic [TAP_W-1:0]   r_k;
    logic [TAP_W-1:0]   r_rp;
    logic               w_load_ok;
    logic [TAP_W-1:0]   w_req_tap;

    assign w_load_ok = (i_in_data.band != 2'd3) && (int'(i_in_data.tap_index) < NUM_TAPS);
    assign w_req_tap = TAP_W'(r_req.tap_index);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.func == FUNC_LOAD) begin
                        n_state = w_load_ok ? S_LOAD_RD : S_IDLE;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_LOAD_RD: n_state = S_LOAD_WR;
            S_LOAD_WR: n_state = S_IDLE;
            S_PUSH:    n_state = S_RUN;
            S_RUN: begin
                if (r_k == K_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_load_out   = 1'b0;
        o_coef_raddr = w_req_tap;
        o_coef_we    = 1'b0;
        o_coef_waddr = w_req_tap;
        o_coef_wdata = i_coef_rdata;
        o_hist_raddr = r_rp;
        o_hist_we    = 1'b0;
        o_hist_waddr = r_head;
        o_hist_wdata = {r_req.left_in, r_req.right_in};
        o_tag        = '0;
        case (r_req.band)
            BAND_LOW:  o_coef_wdata[0] = r_req.coefficient;
            BAND_MID:  o_coef_wdata[1] = r_req.coefficient;
            BAND_HIGH: o_coef_wdata[2] = r_req.coefficient;
            default:   o_coef_wdata    = i_coef_rdata;
        endcase
        case (r_state)
            S_IDLE:    o_in_ready = 1'b1;
            S_LOAD_WR: o_coef_we  = 1'b1;
            S_PUSH:    o_hist_we  = 1'b1;
            S_RUN: begin
                o_coef_raddr = r_k;
                o_tag.vld    = 1'b1;
                o_tag.first  = (r_k == '0);
                o_tag.last   = (r_k == K_LAST);
                o_tag.live   = (FILL_W'(r_k) < r_fill);
            end
            S_DONE:    o_load_out = i_out_free;
            default:   o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_PUSH: begin
                    if (r_fill != FILL_MAX) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                S_RUN: begin
                    if (r_k == K_LAST) begin
                        r_head <= (r_head == K_LAST) ? '0 : r_head + 1'b1;
                    end
                end
                default: r_head <= r_head;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (r_state == S_PUSH) begin
            r_k  <= '0;
            r_rp <= r_head;
        end else if (r_state == S_RUN) begin
            r_k  <= r_k + 1'b1;
            r_rp <= (r_rp == '0) ? K_LAST : r_rp - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tgfe_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgfe_mac: tap and multiply-accumulate pipeline
// Builds each effective tap from the three band coefficients and gains, then
// accumulates both channels and rounds and saturates the sums.
// ----------------------------------------------------------------------------
module tgfe_mac
    import tgfe_pkg::*;
#(
    parameter int NUM_TAPS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_tap_tag   i_tag,
    input  wire t_coef_word i_coef_rdata,
    input  wire t_hist_word i_hist_rdata,
    input  wire t_gain_sel  i_gains,
    output logic            o_done,
    output t_out_item       o_result
);

    localparam int ACC_W = PROD_W + 1 + $clog2(NUM_TAPS);
    localparam int Y_W   = ACC_W + 1 - 15;

    t_tap_tag                  r_tag1;
    t_tap_tag                  r_tag2;
    t_tap_tag                  r_tag3;
    t_tap_tag                  r_tag4;
    logic signed [PROD_W-1:0]  r_p [BAND_CNT];
    logic signed [DATA_W-1:0]  r_xl1;
    logic signed [DATA_W-1:0]  r_xr1;
    logic signed [DATA_W-1:0]  r_xl2;
    logic signed [DATA_W-1:0]  r_xr2;
    logic signed [DATA_W-1:0]  r_h;
    logic signed [PROD_W-1:0]  r_pl;
    logic signed [PROD_W-1:0]  r_pr;
    logic signed [ACC_W-1:0]   r_acc_l;
    logic signed [ACC_W-1:0]   r_acc_r;
    logic signed [DATA_W-1:0]  w_gain [BAND_CNT];
    logic [DATA_W-1:0]         w_h;

    function automatic logic signed [DATA_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W:0] rnd;
        logic [Y_W-1:0] y;
        logic signed [DATA_W-1:0] res;
        rnd = {acc[ACC_W-1], acc} + {{(ACC_W - 14){1'b0}}, 1'b1, 14'd0};
        y   = rnd[ACC_W:15];
        if (y[Y_W-1:DATA_W-1] == {(Y_W - DATA_W + 1){y[DATA_W-1]}}) begin
            res = y[DATA_W-1:0];
        end else begin
            res = y[Y_W-1] ? SAT_MIN : SAT_MAX;
        end
        return res;
    endfunction

    assign w_gain[0] = gain_of(i_gains.low);
    assign w_gain[1] = gain_of(i_gains.mid);
    assign w_gain[2] = gain_of(i_gains.high);

    assign w_h = r_p[0][30:15] + r_p[1][30:15] + r_p[2][30:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            o_done <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            o_done <= r_tag4.vld && r_tag4.last;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < BAND_CNT; b++) begin
            r_p[b] <= $signed(i_coef_rdata[b]) * w_gain[b];
        end
        r_xl1 <= r_tag1.live ? $signed(i_hist_rdata[1]) : '0;
        r_xr1 <= r_tag1.live ? $signed(i_hist_rdata[0]) : '0;
        r_h   <= $signed(w_h);
        r_xl2 <= r_xl1;
        r_xr2 <= r_xr1;
        r_pl  <= r_h * r_xl2;
        r_pr  <= r_h * r_xr2;
        if (r_tag4.vld) begin
            if (r_tag4.first) begin
                r_acc_l <= {{(ACC_W - PROD_W){r_pl[PROD_W-1]}}, r_pl};
                r_acc_r <= {{(ACC_W - PROD_W){r_pr[PROD_W-1]}}, r_pr};
            end else begin
                r_acc_l <= r_acc_l + {{(ACC_W - PROD_W){r_pl[PROD_W-1]}}, r_pl};
                r_acc_r <= r_acc_r + {{(ACC_W - PROD_W){r_pr[PROD_W-1]}}, r_pr};
            end
        end
    end

    assign o_result.left_out  = finish(r_acc_l);
    assign o_result.right_out = finish(r_acc_r);

endmodule
`default_nettype wire

// ===== rtl/three_band_gain_fir_equalizer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_band_gain_fir_equalizer_unit: stereo three-band FIR equalizer
// Loads Q15 band coefficients and filters stereo samples through an
// effective tap built from the three bands and their selected gains.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_ready     i_in_data (t_in_item)
//   output    out        o_out_valid / i_out_ready   o_out_data (t_out_item)
//   config    in         i_cfg_we                    i_cfg_index, i_cfg_wdata
//
// A sample request walks one tap per cycle through the single read port of the
// coefficient and history memories, then drains the pipe.
// A load request performs a read-modify-write of one coefficient word.
// Reset is synchronous; history is zero through a fill count, no clear pass.
// A finished result waits in the output register; loads continue meanwhile.
// ----------------------------------------------------------------------------
module three_band_gain_fir_equalizer_unit
    import tgfe_pkg::*;
#(
    parameter int NUM_TAPS = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SEL_W-1:0]     i_cfg_wdata
);

    localparam int TAP_W = $clog2(NUM_TAPS);

    t_gain_sel          r_gains;
    logic               w_out_free;
    logic               w_done;
    logic               w_load_out;
    t_out_item          w_result;
    t_tap_tag           w_tag;
    t_coef_word         w_coef_rdata;
    t_coef_word         w_coef_wdata;
    logic [TAP_W-1:0]   w_coef_raddr;
    logic [TAP_W-1:0]   w_coef_waddr;
    logic               w_coef_we;
    t_hist_word         w_hist_rdata;
    t_hist_word         w_hist_wdata;
    logic [TAP_W-1:0]   w_hist_raddr;
    logic [TAP_W-1:0]   w_hist_waddr;
    logic               w_hist_we;

    assign w_out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= {SEL_RESET, SEL_RESET, SEL_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_LOW:  r_gains.low  <= i_cfg_wdata;
                CFG_GAIN_MID:  r_gains.mid  <= i_cfg_wdata;
                CFG_GAIN_HIGH: r_gains.high <= i_cfg_wdata;
                default:       r_gains      <= r_gains;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_out_data <= w_result;
        end
    end

    tgfe_ram #(
        .WIDTH (BAND_CNT * DATA_W),
        .DEPTH (NUM_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (w_coef_wdata),
        .i_raddr (w_coef_raddr),
        .o_rdata (w_coef_rdata)
    );

    tgfe_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (NUM_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (w_hist_raddr),
        .o_rdata (w_hist_rdata)
    );

    tgfe_ctrl #(
        .NUM_TAPS (NUM_TAPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_ready   (o_in_ready),
        .i_out_free   (w_out_free),
        .i_done       (w_done),
        .o_load_out   (w_load_out),
        .i_coef_rdata (w_coef_rdata),
        .o_coef_raddr (w_coef_raddr),
        .o_coef_we    (w_coef_we),
        .o_coef_waddr (w_coef_waddr),
        .o_coef_wdata (w_coef_wdata),
        .o_hist_raddr (w_hist_raddr),
        .o_hist_we    (w_hist_we),
        .o_hist_waddr (w_hist_waddr),
        .o_hist_wdata (w_hist_wdata),
        .o_tag        (w_tag)
    );

    tgfe_mac #(
        .NUM_TAPS (NUM_TAPS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (w_tag),
        .i_coef_rdata (w_coef_rdata),
        .i_hist_rdata (w_hist_rdata),
        .i_gains      (r_gains),
        .o_done       (w_done),
        .o_result     (w_result)
    );

endmodule
`default_nettype wire
